### src/art_pkg.sv
// Shared types and constants for the acknowledgement retransmission tracker.
`default_nettype none
package art_pkg;

  // Field widths of the request and result channels.
  localparam int OP_W      = 2;
  localparam int SEQ_W     = 16;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int RETRY_W   = 4;
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Operation codes of an input request.
  localparam logic [OP_W-1:0] OP_TRACK = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_TRACKED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ANSWER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GAVE_UP = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'b1;

  // Configuration reset values.
  localparam logic [TMO_W-1:0]   TMO_RESET   = 16'd1000;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted request, restart the slot walk
    logic rd_en;       // read a slot entry from the table RAM
    logic rd_next;     // read the following slot and advance the index
    logic commit;      // apply the current slot's effect and emit its result
    logic emit_final;  // emit the closing result of the request
  } art_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_track;    // current request is a track request
    logic slot_emit;   // current slot produces a result
    logic last_slot;   // current slot is the highest one
    logic out_free;    // output register can take a result this cycle
  } art_status_t;

endpackage
`default_nettype wire

### src/ack_retransmit_tracker.sv
// Top level: tracks sent messages awaiting acknowledgement and times out resends.
// A request is taken only while the block is idle; it then walks the slots one per cycle while
// no waiting result stalls the walk. A track request stops at the lowest free slot; ack, query
// and tick requests walk every slot.
// A track request without needs_ack completes in its accept cycle and yields no result.
// Reset clears all slot valid bits and loads the timeout (1000 ms) and retry limit (3).
`default_nettype none
module ack_retransmit_tracker #(
  parameter int SLOTS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [art_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [art_pkg::SEQ_W-1:0]     seq_i,
  input  wire logic [art_pkg::TIME_W-1:0]    now_ms_i,
  input  wire logic                          needs_ack_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [art_pkg::KIND_W-1:0]         kind_o,
  output logic [art_pkg::SLOT_W-1:0]         slot_o,
  output logic [art_pkg::SEQ_W-1:0]          seq_out_o,
  output logic                               found_o,
  output logic                               last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [art_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [art_pkg::CFG_W-1:0]     cfg_wdata_i
);

  art_pkg::art_cmd_t    cmd;
  art_pkg::art_status_t status;

  // Sequencing of each request.
  art_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .needs_ack_i (needs_ack_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Slot table and result path.
  art_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .opcode_i    (opcode_i),
    .seq_i       (seq_i),
    .now_ms_i    (now_ms_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .slot_o      (slot_o),
    .seq_out_o   (seq_out_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

### src/art_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module art_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                  wdata_i,
  input  wire logic                              re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/art_ctrl.sv
// Controller state machine that sequences the slot walk for each request.
`default_nettype none
module art_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [art_pkg::OP_W-1:0] opcode_i,
  input  wire logic                     needs_ack_i,
  input  wire art_pkg::art_status_t     status_i,
  output art_pkg::art_cmd_t             cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // A track request without acknowledgement needs no work at all.
          if (!((opcode_i == art_pkg::OP_TRACK) && !needs_ack_i)) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        // Hold the slot while its result cannot be placed.
        if (!(status_i.slot_emit && !status_i.out_free)) begin
          cmd_o.commit = 1'b1;
          if (status_i.is_track && status_i.slot_emit) begin
            state_d = ST_IDLE;
          end else if (status_i.last_slot) begin
            state_d = ST_FINAL;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### src/art_datapath.sv
// Datapath: slot table, slot walk index, timeout check and result register.
`default_nettype none
module art_datapath #(
  parameter int SLOTS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire art_pkg::art_cmd_t             cmd_i,
  output art_pkg::art_status_t               status_o,
  input  wire logic [art_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [art_pkg::SEQ_W-1:0]     seq_i,
  input  wire logic [art_pkg::TIME_W-1:0]    now_ms_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [art_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [art_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [art_pkg::KIND_W-1:0]         kind_o,
  output logic [art_pkg::SLOT_W-1:0]         slot_o,
  output logic [art_pkg::SEQ_W-1:0]          seq_out_o,
  output logic                               found_o,
  output logic                               last_o
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PADW = (IDXW > art_pkg::SLOT_W) ? IDXW : art_pkg::SLOT_W;
  localparam int ENTW = art_pkg::SEQ_W + art_pkg::TIME_W + art_pkg::RETRY_W;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(SLOTS - 1);

  // Request and configuration registers.
  logic [art_pkg::OP_W-1:0]    op_q;
  logic [art_pkg::SEQ_W-1:0]   seq_q;
  logic [art_pkg::TIME_W-1:0]  now_q;
  logic [IDXW-1:0]             idx_q, idx_nxt;
  logic                        found_q;
  logic [SLOTS-1:0]            valid_q;
  logic [art_pkg::TMO_W-1:0]   tmo_q;
  logic [art_pkg::RETRY_W-1:0] maxret_q;

  // Table RAM signals.
  logic                        ram_we;
  logic [ENTW-1:0]             ram_wdata, ram_rdata;
  logic [IDXW-1:0]             ram_raddr;
  logic [art_pkg::SEQ_W-1:0]   rd_seq;
  logic [art_pkg::TIME_W-1:0]  rd_time;
  logic [art_pkg::RETRY_W-1:0] rd_ret;

  // Per-slot decisions.
  logic                        cur_valid, match, timed_out, give_up;
  logic [art_pkg::TIME_W-1:0]  age;
  logic [PADW-1:0]             idx_pad;
  logic                        set_valid, clr_valid, set_found;

  // Result register.
  logic                        out_valid_q;
  logic [art_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [art_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [art_pkg::SEQ_W-1:0]   seq_out_q, seq_out_d;
  logic                        found_out_q, found_out_d;
  logic                        last_q, last_d;
  logic                        emit;

  assign idx_nxt   = idx_q + IDXW'(1);
  assign ram_raddr = cmd_i.rd_next ? idx_nxt : idx_q;

  art_ram #(
    .WIDTH (ENTW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_seq  = ram_rdata[ENTW-1 -: art_pkg::SEQ_W];
  assign rd_time = ram_rdata[art_pkg::RETRY_W +: art_pkg::TIME_W];
  assign rd_ret  = ram_rdata[art_pkg::RETRY_W-1:0];

  // Evaluate the slot whose entry sits in the RAM read register.
  assign cur_valid = valid_q[idx_q];
  assign match     = cur_valid && (rd_seq == seq_q);
  assign age       = now_q - rd_time;
  assign timed_out = cur_valid && (age >= art_pkg::TIME_W'(tmo_q));
  assign give_up   = (rd_ret >= maxret_q);
  assign idx_pad   = PADW'(idx_q);

  // Status toward the controller.
  always_comb begin
    status_o.is_track  = (op_q == art_pkg::OP_TRACK);
    status_o.last_slot = (idx_q == IDX_LAST);
    status_o.out_free  = !out_valid_q || out_ready_i;
    unique case (op_q)
      art_pkg::OP_TRACK: status_o.slot_emit = !cur_valid;
      art_pkg::OP_TICK:  status_o.slot_emit = timed_out;
      default:           status_o.slot_emit = 1'b0;
    endcase
  end

  // Slot effects and results.
  always_comb begin
    ram_we      = 1'b0;
    ram_wdata   = {rd_seq, now_q, rd_ret + art_pkg::RETRY_W'(1)};
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    set_found   = 1'b0;
    emit        = 1'b0;
    kind_d      = art_pkg::KIND_DONE;
    slot_d      = idx_pad[art_pkg::SLOT_W-1:0];
    seq_out_d   = rd_seq;
    found_out_d = 1'b0;
    last_d      = 1'b0;
    if (cmd_i.commit) begin
      unique case (op_q)
        art_pkg::OP_TRACK: begin
          if (!cur_valid) begin
            ram_we    = 1'b1;
            ram_wdata = {seq_q, now_q, art_pkg::RETRY_W'(0)};
            set_valid = 1'b1;
            emit      = 1'b1;
            kind_d    = art_pkg::KIND_TRACKED;
            seq_out_d = seq_q;
            last_d    = 1'b1;
          end
        end
        art_pkg::OP_ACK: begin
          set_found = match;
          clr_valid = match;
        end
        art_pkg::OP_QUERY: begin
          set_found = match;
        end
        art_pkg::OP_TICK: begin
          if (timed_out) begin
            emit = 1'b1;
            if (give_up) begin
              clr_valid = 1'b1;
              kind_d    = art_pkg::KIND_GAVE_UP;
            end else begin
              ram_we    = 1'b1;
              kind_d    = art_pkg::KIND_RESEND;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (cmd_i.emit_final) begin
      emit   = 1'b1;
      slot_d = '0;
      last_d = 1'b1;
      unique case (op_q)
        art_pkg::OP_TRACK: begin
          kind_d    = art_pkg::KIND_FULL;
          seq_out_d = seq_q;
        end
        art_pkg::OP_ACK, art_pkg::OP_QUERY: begin
          kind_d      = art_pkg::KIND_ANSWER;
          seq_out_d   = seq_q;
          found_out_d = found_q;
        end
        art_pkg::OP_TICK: begin
          kind_d    = art_pkg::KIND_DONE;
          seq_out_d = '0;
        end
        default: begin
          kind_d = art_pkg::KIND_DONE;
        end
      endcase
    end
  end

  // Request capture and walk index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      seq_q <= seq_i;
      now_q <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en && cmd_i.rd_next) begin
        idx_q <= idx_nxt;
      end
      if (set_found) begin
        found_q <= 1'b1;
      end
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (set_valid) begin
      valid_q[idx_q] <= 1'b1;
    end else if (clr_valid) begin
      valid_q[idx_q] <= 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q    <= art_pkg::TMO_RESET;
      maxret_q <= art_pkg::RETRY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        art_pkg::CFG_ACK_TIMEOUT: tmo_q    <= cfg_wdata_i;
        art_pkg::CFG_MAX_RETRIES: maxret_q <= cfg_wdata_i[art_pkg::RETRY_W-1:0];
        default:                  tmo_q    <= tmo_q;
      endcase
    end
  end

  // Output register; a new result is only emitted when the register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q      <= kind_d;
      slot_q      <= slot_d;
      seq_out_q   <= seq_out_d;
      found_out_q <= found_out_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_q;
  assign seq_out_o   = seq_out_q;
  assign found_o     = found_out_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

### src/art_checker.sv
// Port-level checker for the tracker and its bind to the top level.
`default_nettype none
module art_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [art_pkg::OP_W-1:0]      opcode_i,
  input wire logic                          needs_ack_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [art_pkg::KIND_W-1:0]    kind_o,
  input wire logic [art_pkg::SLOT_W-1:0]    slot_o,
  input wire logic [art_pkg::SEQ_W-1:0]     seq_out_o,
  input wire logic                          found_o,
  input wire logic                          last_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(slot_o)
      && $stable(seq_out_o) && $stable(found_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A request that has work to do keeps the input closed on the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !((opcode_i == art_pkg::OP_TRACK) && !needs_ack_i) |=> !in_ready_o)
    else $error("request accepted while a previous one is in progress");

  // Only per-slot tick results are not the final result of a request.
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> kind_o == art_pkg::KIND_RESEND
      || kind_o == art_pkg::KIND_GAVE_UP)
    else $error("non-final result of an unexpected kind");

  // The found flag is only raised on an ack or query answer.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> kind_o == art_pkg::KIND_ANSWER && last_o)
    else $error("found flag on a result other than an answer");

endmodule

bind ack_retransmit_tracker art_checker u_art_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .opcode_i    (opcode_i),
  .needs_ack_i (needs_ack_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .slot_o      (slot_o),
  .seq_out_o   (seq_out_o),
  .found_o     (found_o),
  .last_o      (last_o)
);
`default_nettype wire
